// ===== hw/rtl/epse_pkg.sv =====
// Shared constants and types for the encoder period speed estimator.
`timescale 1ns / 1ps

package epse_pkg;

  // Default structure parameters
  localparam int unsigned DEFAULT_HISTORY_DEPTH = 4;
  localparam int unsigned DEFAULT_FRACTION_BITS = 8;

  // Fixed field widths
  localparam int unsigned TS_W       = 32;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned SPEED_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd1;

  // Register reset values
  localparam logic [TS_W-1:0]    TIMEOUT_RESET = 32'd111111;
  localparam logic [SCALE_W-1:0] SCALE_RESET   = 24'd111111;

  // Input command codes
  localparam logic CMD_PULSE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

endpackage

// ===== hw/rtl/encoder_period_speed_estimator.sv =====
// Encoder speed estimator: period history, summing pass and radix-2 divider.
`timescale 1ns / 1ps
// A pulse item yields no result and leaves ready high; a stalled query skips the sum and divide.
// Other queries run a summing pass and a radix-2 divider: one adder sums the history, then
// restores one quotient bit a cycle. A zero history sum gives zero speed without the division
// steps; ready stays low until the result enters the output register, and longer while a
// waiting result still holds that register.
// Reset (rst_ni low, async) clears history, pulse times, sequencer, output valid; loads registers.

module encoder_period_speed_estimator #(
  parameter int unsigned HISTORY_DEPTH = epse_pkg::DEFAULT_HISTORY_DEPTH,
  parameter int unsigned FRACTION_BITS = epse_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [epse_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [epse_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [epse_pkg::TS_W-1:0]       s_axis_tdata_i,  // [31:0] timestamp_us
  input  logic                            s_axis_tuser_i,  // [0] command
  // result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [epse_pkg::SPEED_W-1:0]    m_axis_tdata_o,  // [31:0] speed
  output logic                            m_axis_tuser_o   // [0] stalled
);

  localparam int unsigned TS_W    = epse_pkg::TS_W;
  localparam int unsigned SPEED_W = epse_pkg::SPEED_W;
  localparam int unsigned SUM_W   = TS_W + $clog2(HISTORY_DEPTH);
  localparam int unsigned AW      = SUM_W + 1;
  localparam int unsigned NUM_W   = epse_pkg::SCALE_W + FRACTION_BITS
                                    + $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CNT_W   = $clog2(NUM_W + 1);
  localparam int unsigned IDX_W   = $clog2(HISTORY_DEPTH);
  localparam int unsigned QX_W    = ((NUM_W > SPEED_W) ? NUM_W : SPEED_W) + 1;

  epse_pkg::state_e state_q, state_d;

  logic [TS_W-1:0]                timeout_q;
  logic [epse_pkg::SCALE_W-1:0]   scale_q;
  logic [TS_W-1:0]                hist_q [HISTORY_DEPTH];
  logic [TS_W-1:0]                last_q, prior_q;
  logic [AW-1:0]                  acc_q, acc_d;
  logic [SUM_W-1:0]               rem_q, rem_d;
  logic [NUM_W-1:0]               num_q, num_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [IDX_W-1:0]               idx_q, idx_d;
  logic [SPEED_W-1:0]             res_speed_q, res_speed_d;
  logic                           res_stall_q, res_stall_d;
  logic                           out_valid_q, out_valid_d;
  logic [SPEED_W-1:0]             out_speed_q;
  logic                           out_stall_q;

  logic                           in_acc;
  logic                           out_load;
  logic [TS_W-1:0]                elapsed;
  logic [TS_W-1:0]                last_period;
  logic                           is_stall;

  logic [AW-1:0]                  alu_a, alu_b;
  logic                           alu_cin;
  logic [AW:0]                    alu_res;
  logic [AW-1:0]                  rem_sh;
  logic [QX_W-1:0]                q_ext;

  assign s_axis_tready_o = (state_q == epse_pkg::S_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign elapsed         = s_axis_tdata_i - last_q;
  assign last_period     = last_q - prior_q;
  assign is_stall        = (elapsed > timeout_q);

  // Shared add/subtract unit: history sum, then divider trial subtraction
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  always_comb begin
    if (state_q == epse_pkg::S_SUM) begin
      alu_a   = acc_q;
      alu_b   = AW'(hist_q[idx_q]);
      alu_cin = 1'b0;
    end else begin
      alu_a   = rem_sh;
      alu_b   = ~acc_q;
      alu_cin = 1'b1;
    end
    alu_res = {1'b0, alu_a} + {1'b0, alu_b} + (AW + 1)'(alu_cin);
  end

  // Saturate the quotient taken after the final division step
  assign q_ext = QX_W'({num_q[NUM_W-2:0], alu_res[AW]});

  // Sequencer
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    num_d       = num_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    res_speed_d = res_speed_q;
    res_stall_d = res_stall_q;
    out_load    = 1'b0;
    case (state_q)
      epse_pkg::S_IDLE: begin
        if (in_acc && (s_axis_tuser_i == epse_pkg::CMD_QUERY)) begin
          if (is_stall) begin
            res_speed_d = '0;
            res_stall_d = 1'b1;
            state_d     = epse_pkg::S_DONE;
          end else begin
            acc_d       = '0;
            idx_d       = '0;
            res_stall_d = 1'b0;
            state_d     = epse_pkg::S_SUM;
          end
        end
      end
      epse_pkg::S_SUM: begin
        acc_d = alu_res[AW-1:0];
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(HISTORY_DEPTH - 1)) begin
          rem_d   = '0;
          num_d   = (NUM_W'(scale_q) * NUM_W'(HISTORY_DEPTH)) << FRACTION_BITS;
          cnt_d   = CNT_W'(NUM_W);
          state_d = epse_pkg::S_DIV;
        end
      end
      epse_pkg::S_DIV: begin
        if (acc_q == '0) begin
          // empty history gives zero speed
          res_speed_d = '0;
          state_d     = epse_pkg::S_DONE;
        end else begin
          if (alu_res[AW]) begin
            rem_d = alu_res[SUM_W-1:0];
          end else begin
            rem_d = rem_sh[SUM_W-1:0];
          end
          num_d = {num_q[NUM_W-2:0], alu_res[AW]};
          cnt_d = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            res_speed_d = (|q_ext[QX_W-1:SPEED_W]) ? '1 : q_ext[SPEED_W-1:0];
            state_d     = epse_pkg::S_DONE;
          end
        end
      end
      epse_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = epse_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = epse_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q & ~m_axis_tready_i) | out_load;

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= epse_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      timeout_q   <= epse_pkg::TIMEOUT_RESET;
      scale_q     <= epse_pkg::SCALE_RESET;
      last_q      <= '0;
      prior_q     <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          epse_pkg::CFG_TIMEOUT: timeout_q <= cfg_wdata_i[TS_W-1:0];
          epse_pkg::CFG_SCALE:   scale_q   <= cfg_wdata_i[epse_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      // history update on accepted items
      if (in_acc) begin
        if (s_axis_tuser_i == epse_pkg::CMD_PULSE) begin
          prior_q <= last_q;
          last_q  <= s_axis_tdata_i;
          for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            hist_q[i] <= hist_q[i+1];
          end
          hist_q[HISTORY_DEPTH-1] <= s_axis_tdata_i - last_q;
        end else if (!is_stall) begin
          hist_q[HISTORY_DEPTH-1] <= (last_period > elapsed) ? last_period : elapsed;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    rem_q       <= rem_d;
    num_q       <= num_d;
    cnt_q       <= cnt_d;
    idx_q       <= idx_d;
    res_speed_q <= res_speed_d;
    res_stall_q <= res_stall_d;
    if (out_load) begin
      out_speed_q <= res_speed_q;
      out_stall_q <= res_stall_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_speed_q;
  assign m_axis_tuser_o  = out_stall_q;

endmodule

// ===== hw/rtl/epse_checker.sv =====
// Port-level assertions for the encoder period speed estimator, bound to the top level.
`timescale 1ns / 1ps

module epse_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         s_axis_tuser_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [epse_pkg::SPEED_W-1:0] m_axis_tdata_o,
  input logic                         m_axis_tuser_o
);

  // Hold a waiting result steady until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o)))
    else $error("result changed while stalled");

  // A stalled result always reads zero speed
  a_stall_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("stalled result with nonzero speed");

  // A pulse item never produces a result
  a_pulse_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == epse_pkg::CMD_PULSE)
      && !m_axis_tvalid_o) |=> !m_axis_tvalid_o)
    else $error("result appeared after a pulse item");

  // Drop ready while a query is being worked on
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == epse_pkg::CMD_QUERY))
      |=> !s_axis_tready_o)
    else $error("ready high straight after a query item");

endmodule

bind encoder_period_speed_estimator epse_checker u_epse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the encoder period speed estimator.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned HIST_DEPTH   = epse_pkg::DEFAULT_HISTORY_DEPTH;
  localparam int unsigned FRAC_BITS    = epse_pkg::DEFAULT_FRACTION_BITS;
  localparam int unsigned TS_W         = epse_pkg::TS_W;
  localparam int unsigned SPEED_W      = epse_pkg::SPEED_W;
  localparam int unsigned SCALE_W      = epse_pkg::SCALE_W;
  localparam int unsigned CFG_IDX_W    = epse_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W   = epse_pkg::CFG_DATA_W;
  localparam int unsigned DRAIN_CYCLES = 50;    // covers a full query plus margin
  localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int unsigned IDLE_LIMIT   = 5000;  // cycles with no item moving
  localparam int unsigned PHASE_ITEMS  = 72;
  localparam int unsigned NUM_PHASES   = 6;

  // Indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               stalled;
  } speed_res_t;

  typedef struct {
    bit         typed;
    speed_res_t res;
  } typed_speed_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic                 cmd;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          value;
    bit                   typed;
    speed_res_t           res;
  } stim_row_t;

  // Clock, reset and block inputs
  logic                  clk_i     = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = epse_pkg::CFG_TIMEOUT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic [TS_W-1:0]       s_tdata   = '0;
  logic                  s_tuser   = epse_pkg::CMD_PULSE;
  logic                  m_tready  = 1'b0;

  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [SPEED_W-1:0]    m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  // Speed predictor state
  logic [TS_W-1:0]    period_hist [HIST_DEPTH];
  logic [TS_W-1:0]    last_pulse_ts;
  logic [TS_W-1:0]    prior_pulse_ts;
  logic [TS_W-1:0]    timeout_reg;
  logic [SCALE_W-1:0] scale_reg;

  speed_res_t   speed_expect_q [$];
  typed_speed_t typed_speed_q [$];
  stim_row_t    directed_rows [$];

  int unsigned mismatch_cnt = 0;
  int unsigned pulse_cnt    = 0;
  int unsigned query_cnt    = 0;
  int unsigned stall_cnt    = 0;
  int unsigned sat_cnt      = 0;
  int unsigned setting_cnt  = 0;
  int unsigned idle_cycles  = 0;
  int unsigned burst_left   = 1;
  bit          steady       = 1'b0;
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;
  logic [TS_W-1:0] timer_now = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  encoder_period_speed_estimator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),   // [31:0] timestamp_us
    .s_axis_tuser_i  (s_tuser),   // [0] command
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [31:0] speed
    .m_axis_tuser_o  (m_axis_tuser_o)   // [0] stalled
  );

  // Clear the predictor to its reset state
  task automatic clear_speed_state();
    for (int i = 0; i < HIST_DEPTH; i++) period_hist[i] = '0;
    last_pulse_ts  = '0;
    prior_pulse_ts = '0;
    timeout_reg    = epse_pkg::TIMEOUT_RESET;
    scale_reg      = epse_pkg::SCALE_RESET;
  endtask

  // Advance the history by one item; a query also yields the expected speed
  function automatic void track_speed(input logic cmd, input logic [TS_W-1:0] ts,
                                      output bit yields, output speed_res_t res);
    logic [TS_W-1:0] elapsed;
    logic [TS_W-1:0] last_period;
    logic [63:0]     hist_sum;
    logic [63:0]     numer;
    logic [63:0]     quot;
    yields = 1'b0;
    res    = '0;
    if (cmd == epse_pkg::CMD_PULSE) begin
      prior_pulse_ts = last_pulse_ts;
      last_pulse_ts  = ts;
      for (int i = 0; i < HIST_DEPTH - 1; i++) period_hist[i] = period_hist[i + 1];
      period_hist[HIST_DEPTH - 1] = last_pulse_ts - prior_pulse_ts;
    end else begin
      yields  = 1'b1;
      elapsed = ts - last_pulse_ts;
      if (elapsed > timeout_reg) begin
        res.stalled = 1'b1;
      end else begin
        last_period = last_pulse_ts - prior_pulse_ts;
        period_hist[HIST_DEPTH - 1] = (last_period > elapsed) ? last_period : elapsed;
        hist_sum = '0;
        for (int i = 0; i < HIST_DEPTH; i++) hist_sum += {32'd0, period_hist[i]};
        if (hist_sum != 0) begin
          numer = ({40'd0, scale_reg} << FRAC_BITS) * HIST_DEPTH;
          quot  = numer / hist_sum;
          res.speed = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Check results, track register writes and predict on accepted items
  always @(posedge clk_i) begin
    speed_res_t   got;
    speed_res_t   want;
    typed_speed_t typed;
    bit           yields;
    if (rst_n) begin
      if (m_axis_tvalid_o && m_tready) begin
        got.speed   = m_axis_tdata_o;
        got.stalled = m_axis_tuser_o;
        if (speed_expect_q.size() == 0) begin
          report_mismatch("result with none expected", got.speed, '0);
        end else begin
          want = speed_expect_q.pop_front();
          if (got.speed !== want.speed) report_mismatch("speed", got.speed, want.speed);
          if (got.stalled !== want.stalled)
            report_mismatch("stalled", {31'd0, got.stalled}, {31'd0, want.stalled});
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          epse_pkg::CFG_TIMEOUT: timeout_reg = cfg_wdata;
          epse_pkg::CFG_SCALE:   scale_reg   = cfg_wdata[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_axis_tready_o) begin
        track_speed(s_tuser, s_tdata, yields, want);
        if (s_tuser == epse_pkg::CMD_PULSE) pulse_cnt++;
        else query_cnt++;
        if (yields) begin
          if (typed_speed_q.size() > 0) begin
            typed = typed_speed_q.pop_front();
            if (typed.typed) want = typed.res;
          end
          if (want.stalled) stall_cnt++;
          if (want.speed == '1) sat_cnt++;
          speed_expect_q.push_back(want);
        end
      end
    end
  end

  // End the run when no item moves for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: stall in random modes, and hold off once for a long stretch
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    mode = 0;
    span = 0;
    tick = 0;
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(16, 96);
        end
        span--;
        tick++;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= (tick % 4 == 0);
          default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Offer one item and hold it until it is taken
  task automatic send_item(input logic cmd, input logic [TS_W-1:0] ts);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= ts;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Unless steady, insert a random gap at the end of each burst
  task automatic pace_sender();
    int unsigned gap;
    if (!steady) begin
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap        = $urandom_range(0, 45);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  // Stop offering, wait for every result, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (speed_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic stim_row_t item_row(input logic cmd, input logic [31:0] ts);
    stim_row_t row;
    row.kind  = ROW_ITEM;
    row.cmd   = cmd;
    row.idx   = epse_pkg::CFG_TIMEOUT;
    row.value = ts;
    row.typed = 1'b0;
    row.res   = '0;
    return row;
  endfunction

  function automatic stim_row_t query_row(input logic [31:0] ts, input logic [31:0] speed,
                                         input logic stalled);
    stim_row_t row;
    row             = item_row(epse_pkg::CMD_QUERY, ts);
    row.typed       = 1'b1;
    row.res.speed   = speed;
    row.res.stalled = stalled;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [31:0] value);
    stim_row_t row;
    row       = item_row(epse_pkg::CMD_PULSE, value);
    row.kind  = ROW_CFG;
    row.idx   = idx;
    return row;
  endfunction

  // Random item along a running timer, with jumps, wraps and steps back
  task automatic next_random_item(output logic cmd, output logic [TS_W-1:0] ts);
    int unsigned pick;
    logic [TS_W-1:0] delta;
    cmd  = ($urandom_range(0, 1) == 0) ? epse_pkg::CMD_PULSE : epse_pkg::CMD_QUERY;
    pick = $urandom_range(0, 99);
    if (pick < 60)      delta = $urandom_range(0, 3000);
    else if (pick < 80) delta = $urandom_range(0, 250000);
    else if (pick < 90) delta = $urandom;
    else if (pick < 95) delta = '0;
    else begin
      timer_now = timer_now - $urandom_range(1, 5000);
      delta     = '0;
    end
    ts        = timer_now + delta;
    timer_now = ts;
  endtask

  initial begin : stimulus
    logic [TS_W-1:0] ts;
    logic            cmd;
    typed_speed_t    typed;
    logic [31:0]     phase_timeout;
    logic [31:0]     phase_scale;

    clear_speed_state();
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state, timeout edge, wrap, saturation, register extremes
    directed_rows.push_back(query_row(32'd0, 32'd0, 1'b0));
    directed_rows.push_back(query_row(32'd111112, 32'd0, 1'b1));
    directed_rows.push_back(query_row(32'd111111, 32'd1024, 1'b0));
    directed_rows.push_back(item_row(epse_pkg::CMD_PULSE, 32'd100));
    directed_rows.push_back(item_row(epse_pkg::CMD_QUERY, 32'd100));
    directed_rows.push_back(item_row(epse_pkg::CMD_PULSE, 32'd200));
    directed_rows.push_back(item_row(epse_pkg::CMD_PULSE, 32'd300));
    directed_rows.push_back(item_row(epse_pkg::CMD_PULSE, 32'd400));
    directed_rows.push_back(item_row(epse_pkg::CMD_QUERY, 32'd450));
    directed_rows.push_back(item_row(epse_pkg::CMD_QUERY, 32'd700));
    directed_rows.push_back(item_row(epse_pkg::CMD_PULSE, 32'hFFFF_FFF0));
    directed_rows.push_back(item_row(epse_pkg::CMD_QUERY, 32'hFFFF_FFFF));
    directed_rows.push_back(item_row(epse_pkg::CMD_PULSE, 32'h0000_0010));
    directed_rows.push_back(item_row(epse_pkg::CMD_QUERY, 32'h0000_0020));
    directed_rows.push_back(cfg_row(epse_pkg::CFG_SCALE, 32'hFFFF_FFFF));
    repeat (4) directed_rows.push_back(item_row(epse_pkg::CMD_PULSE, 32'h0000_0011));
    directed_rows.push_back(query_row(32'h0000_0011, 32'hFFFF_FFFF, 1'b0));
    directed_rows.push_back(cfg_row(epse_pkg::CFG_TIMEOUT, 32'd0));
    directed_rows.push_back(query_row(32'h0000_0011, 32'hFFFF_FFFF, 1'b0));
    directed_rows.push_back(query_row(32'h0000_0012, 32'd0, 1'b1));
    directed_rows.push_back(cfg_row(epse_pkg::CFG_SCALE, 32'hFF00_0000));
    directed_rows.push_back(query_row(32'h0000_0011, 32'd0, 1'b0));
    directed_rows.push_back(cfg_row(CFG_SPARE_B, 32'hFFFF_FFFF));
    directed_rows.push_back(cfg_row(epse_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF));
    directed_rows.push_back(cfg_row(epse_pkg::CFG_SCALE, 32'h00FF_FFFF));
    directed_rows.push_back(item_row(epse_pkg::CMD_QUERY, 32'h0000_0010));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
        setting_cnt++;
      end else begin
        if (directed_rows[i].cmd == epse_pkg::CMD_QUERY) begin
          typed.typed = directed_rows[i].typed;
          typed.res   = directed_rows[i].res;
          typed_speed_q.push_back(typed);
        end
        send_item(directed_rows[i].cmd, directed_rows[i].value);
        pace_sender();
      end
    end

    // Random phases, each under its own register setting
    timer_now = 32'h0000_0010;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          phase_timeout = epse_pkg::TIMEOUT_RESET;
          phase_scale   = 32'(epse_pkg::SCALE_RESET);
        end
        1: begin phase_timeout = 32'hFFFF_FFFF; phase_scale = 32'h00FF_FFFF; end
        2: begin phase_timeout = 32'd1;         phase_scale = 32'd1;         end
        3: begin
          phase_timeout = $urandom_range(500, 5000);
          phase_scale   = $urandom_range(1, 32'h00FF_FFFF);
        end
        4: begin phase_timeout = $urandom; phase_scale = $urandom; end
        default: begin phase_timeout = 32'd300000; phase_scale = 32'd1000; end
      endcase
      drain();
      write_reg(epse_pkg::CFG_TIMEOUT, phase_timeout);
      write_reg(epse_pkg::CFG_SCALE, phase_scale);
      if (phase == 4) write_reg(CFG_SPARE_A, $urandom);
      setting_cnt++;

      // Phase one keeps offering queries through a long receiver hold-off
      steady   = (phase == 1) || (phase == 4);
      hold_req = (phase == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        next_random_item(cmd, ts);
        if (phase == 1 && n < 24) cmd = epse_pkg::CMD_QUERY;
        send_item(cmd, ts);
        pace_sender();
      end
    end

    drain();
    $display("Run covered %0d pulses and %0d queries under %0d register settings.",
             pulse_cnt, query_cnt, setting_cnt);
    $display("Results: %0d stalled, %0d saturated; receiver held off %0d cycles once.",
             stall_cnt, sat_cnt, HOLD_CYCLES);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
